[src/punrank_pkg.sv]
`timescale 1ns / 1ps
// shared widths, factorial table and digit sizing for the permutation unranker
// no dependencies

package punrank_pkg;

	localparam int RANK_W = 62;
	localparam int ELEM_W = 5;
	localparam int LEN_W  = 5;

	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [LEN_W-1:0]  len_t;

	// n! for n = 0..20
	function automatic rank_t fact(input len_t n);
		rank_t f;
		case (n)
			5'd0:    f = 62'd1;
			5'd1:    f = 62'd1;
			5'd2:    f = 62'd2;
			5'd3:    f = 62'd6;
			5'd4:    f = 62'd24;
			5'd5:    f = 62'd120;
			5'd6:    f = 62'd720;
			5'd7:    f = 62'd5040;
			5'd8:    f = 62'd40320;
			5'd9:    f = 62'd362880;
			5'd10:   f = 62'd3628800;
			5'd11:   f = 62'd39916800;
			5'd12:   f = 62'd479001600;
			5'd13:   f = 62'd6227020800;
			5'd14:   f = 62'd87178291200;
			5'd15:   f = 62'd1307674368000;
			5'd16:   f = 62'd20922789888000;
			5'd17:   f = 62'd355687428096000;
			5'd18:   f = 62'd6402373705728000;
			5'd19:   f = 62'd121645100408832000;
			5'd20:   f = 62'd2432902008176640000;
			default: f = '0;
		endcase
		return f;
	endfunction

	// bits needed for a digit below left+1
	function automatic logic [2:0] digit_bits(input len_t left);
		logic [2:0] b;
		if (left >= 5'd16)     b = 3'd5;
		else if (left >= 5'd8) b = 3'd4;
		else if (left >= 5'd4) b = 3'd3;
		else if (left >= 5'd2) b = 3'd2;
		else if (left >= 5'd1) b = 3'd1;
		else                   b = 3'd0;
		return b;
	endfunction

	// divisor aligned to the top digit bit: left! << (digit_bits - 1)
	function automatic rank_t fact_top(input len_t left);
		logic [2:0] b;
		rank_t      f;
		b = digit_bits(left);
		f = fact(left);
		if (b != 3'd0) f = f << (b - 3'd1);
		return f;
	endfunction

endpackage

[src/permutation_unrank.sv]
`timescale 1ns / 1ps
// lexicographic permutation unranker: rank in, one element word per position out
// depends on punrank_pkg (widths, factorial table)
//
// channel   direction  handshake                       payload
// command   in         start & !busy                   rank
// result    out        result_valid (one cycle)        element, last, bad_rank
// config    in         cfg_valid & cfg_ready           cfg_data (perm_length)
//
// a rank at or above len! gives one word with bad_rank set
// digits come from the shared 62-bit compare/subtract, one quotient bit a cycle
// reset restores perm_length to 20 and returns the sequencer to idle
// busy stays high from the accepted command until its last word is shown;
// the receiver cannot stall, each word is shown for exactly one cycle

module permutation_unrank #(
	parameter int MAX_LEN = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [punrank_pkg::RANK_W-1:0] rank,
	output logic                       result_valid,
	output logic [punrank_pkg::ELEM_W-1:0] element,
	output logic                       last,
	output logic                       bad_rank,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [punrank_pkg::LEN_W-1:0] cfg_data
);

	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [punrank_pkg::LEN_W-1:0] MAX_LEN_V = punrank_pkg::LEN_W'(MAX_LEN);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]                  state_q;
	punrank_pkg::len_t           perm_length_q;
	punrank_pkg::len_t           len_q;
	punrank_pkg::len_t           left_q;
	punrank_pkg::len_t           count_q;
	punrank_pkg::len_t           digit_q;
	logic [2:0]                  step_q;
	punrank_pkg::rank_t          rest_q;
	punrank_pkg::rank_t          div_q;
	punrank_pkg::elem_t          unused_q [MAX_LEN];
	logic                        result_valid_q;
	punrank_pkg::elem_t          element_q;
	logic                        last_q;
	logic                        bad_rank_q;

	punrank_pkg::len_t           eff_len;
	logic [punrank_pkg::RANK_W:0] diff;
	logic                        ge;
	punrank_pkg::len_t           dsel;
	logic [IDX_W-1:0]            didx;
	punrank_pkg::len_t           nleft;

	always_comb begin
		if (perm_length_q == '0)           eff_len = punrank_pkg::LEN_W'(1);
		else if (perm_length_q > MAX_LEN_V) eff_len = MAX_LEN_V;
		else                               eff_len = perm_length_q;
	end

	// shared unit: one wide subtract, borrow gives the compare
	assign diff = {1'b0, rest_q} - {1'b0, div_q};
	assign ge   = !diff[punrank_pkg::RANK_W];

	always_comb begin
		if (digit_q >= count_q) dsel = count_q - punrank_pkg::LEN_W'(1);
		else                    dsel = digit_q;
	end
	assign didx  = dsel[IDX_W-1:0];
	assign nleft = (state_q == ST_CHECK) ? len_q - punrank_pkg::LEN_W'(1)
	                                     : left_q - punrank_pkg::LEN_W'(1);

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign element      = element_q;
	assign last         = last_q;
	assign bad_rank     = bad_rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_length_q <= punrank_pkg::LEN_W'(20);
		end else if (cfg_valid && cfg_ready) begin
			perm_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					// range check on the shared unit: rank against len!
					if (ge) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end else if (punrank_pkg::digit_bits(nleft) == 3'd0) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == 3'd1) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					result_valid_q <= 1'b1;
					if (left_q == '0) begin
						state_q <= ST_IDLE;
					end else if (punrank_pkg::digit_bits(nleft) == 3'd0) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rest_q <= rank;
				len_q  <= eff_len;
				div_q  <= punrank_pkg::fact(eff_len);
			end
			ST_CHECK: begin
				element_q  <= '0;
				last_q     <= 1'b1;
				bad_rank_q <= 1'b1;
				count_q    <= len_q;
				left_q     <= nleft;
				div_q      <= punrank_pkg::fact_top(nleft);
				step_q     <= punrank_pkg::digit_bits(nleft);
				digit_q    <= '0;
				for (int k = 0; k < MAX_LEN; k++) begin
					unused_q[k] <= punrank_pkg::ELEM_W'(k);
				end
			end
			ST_DIV: begin
				if (ge) rest_q <= diff[punrank_pkg::RANK_W-1:0];
				digit_q <= {digit_q[punrank_pkg::LEN_W-2:0], ge};
				div_q   <= div_q >> 1;
				step_q  <= step_q - 3'd1;
			end
			ST_EMIT: begin
				element_q  <= unused_q[didx];
				last_q     <= (left_q == '0);
				bad_rank_q <= 1'b0;
				// close the gap left by the picked value
				for (int k = 0; k < MAX_LEN - 1; k++) begin
					if (IDX_W'(k) >= didx) unused_q[k] <= unused_q[k+1];
				end
				count_q <= count_q - punrank_pkg::LEN_W'(1);
				left_q  <= nleft;
				div_q   <= punrank_pkg::fact_top(nleft);
				step_q  <= punrank_pkg::digit_bits(nleft);
				digit_q <= '0;
			end
			default: ;
		endcase
	end

	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result word without a command in progress");

	a_bad_word_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bad_rank |-> last && (element == '0))
		else $error("bad rank word must be last with element zero");

	a_last_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("still busy after the last word");

	a_more_words: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("went idle before the last word");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

endmodule

[test/tb_permutation_unrank.sv]
`timescale 1ns / 1ps
// self-checking testbench for permutation_unrank: directed and random ranks over several lengths
// depends on punrank_pkg and permutation_unrank

module tb_permutation_unrank;

	localparam int MAX_PERM  = 20;
	localparam int LIMIT     = 200000;
	localparam int SETTLE    = 100;
	localparam int SEG_ITEMS = 28;

	typedef struct packed {
		punrank_pkg::elem_t element;
		logic               last;
		logic               bad_rank;
	} perm_word_t;

	// tracks the length register and the element words still owed by the block
	class perm_tracker;
		logic [63:0]        fact_of [MAX_PERM+1];
		punrank_pkg::len_t  length_reg;
		perm_word_t         owed_words [$];
		int unsigned        errors;

		function new();
			fact_of[0] = 64'd1;
			for (int i = 1; i <= MAX_PERM; i++) fact_of[i] = fact_of[i-1] * 64'(i);
			length_reg = punrank_pkg::len_t'(MAX_PERM);
			errors = 0;
		endfunction

		function void set_length(input punrank_pkg::len_t v);
			length_reg = v;
		endfunction

		function int unsigned eff_len();
			int unsigned n;
			n = 32'(length_reg);
			if (n < 1) n = 1;
			if (n > MAX_PERM) n = MAX_PERM;
			return n;
		endfunction

		function int unsigned pending();
			return owed_words.size();
		endfunction

		// expand one accepted rank into its element words
		function void add_rank(input punrank_pkg::rank_t r);
			int unsigned        n;
			int unsigned        count;
			int unsigned        left;
			int unsigned        d;
			logic [63:0]        rest;
			logic [63:0]        digit;
			punrank_pkg::elem_t pool [MAX_PERM];
			perm_word_t         w;
			n = eff_len();
			rest = {2'b00, r};
			if (rest >= fact_of[n]) begin
				w.element = '0;
				w.last = 1'b1;
				w.bad_rank = 1'b1;
				owed_words.push_back(w);
				return;
			end
			for (int i = 0; i < n; i++) pool[i] = punrank_pkg::elem_t'(i);
			count = n;
			for (int pos = 0; pos < n; pos++) begin
				left = n - 1 - 32'(pos);
				digit = rest / fact_of[left];
				rest = rest % fact_of[left];
				if (digit >= 64'(count)) digit = 64'(count - 1);
				d = digit[31:0];
				w.element = pool[d];
				w.last = (pos == n - 1);
				w.bad_rank = 1'b0;
				owed_words.push_back(w);
				for (int k = int'(d); k + 1 < count; k++) pool[k] = pool[k+1];
				count--;
			end
		endfunction

		function void check_word(input punrank_pkg::elem_t e, input logic l, input logic b);
			perm_word_t want;
			if (owed_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: element %0d last %0b bad_rank %0b", e, l, b);
				return;
			end
			want = owed_words.pop_front();
			if (want.element !== e || want.last !== l || want.bad_rank !== b) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp element %0d last %0b bad %0b, got %0d %0b %0b",
						want.element, want.last, want.bad_rank, e, l, b);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	punrank_pkg::rank_t rank = '0;
	logic               cfg_valid = 1'b0;
	punrank_pkg::len_t  cfg_data = '0;
	logic               busy;
	logic               result_valid;
	punrank_pkg::elem_t element;
	logic               last;
	logic               bad_rank;
	logic               cfg_ready;

	perm_tracker tracker = new();
	int unsigned idle_pct = 38;
	int unsigned cycle_count = 0;

	permutation_unrank dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.rank         (rank),
		.result_valid (result_valid),
		.element      (element),
		.last         (last),
		.bad_rank     (bad_rank),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) tracker.check_word(element, last, bad_rank);
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("permutation_unrank regression: fail");
		$finish;
	end

	task automatic send_rank(input punrank_pkg::rank_t r);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct && gap < 12) gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		rank <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		tracker.add_rank(r);
	endtask

	task automatic drain_words();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(input punrank_pkg::len_t v);
		drain_words();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tracker.set_length(v);
	endtask

	// mostly valid ranks, some right at the n! boundary, some anywhere in 62 bits
	function automatic punrank_pkg::rank_t pick_rank(input int unsigned n);
		logic [63:0] wide;
		logic [63:0] lim;
		int unsigned sel;
		lim = tracker.fact_of[n];
		wide = {$urandom, $urandom};
		sel = $urandom_range(0, 99);
		if (sel < 75) return punrank_pkg::rank_t'(wide % lim);
		else if (sel < 85) return punrank_pkg::rank_t'(lim - 1 + 64'($urandom_range(0, 1)));
		else return wide[punrank_pkg::RANK_W-1:0];
	endfunction

	initial begin
		punrank_pkg::len_t seg_len [9];
		seg_len = '{5'd20, 5'd1, 5'd31, 5'd4, 5'd0, 5'd12, 5'd21, 5'd20, 5'd20};
		seg_len[7] = punrank_pkg::len_t'($urandom_range(2, 19));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length of 20
		send_rank('0);
		send_rank(punrank_pkg::rank_t'(1));
		send_rank(punrank_pkg::rank_t'(tracker.fact_of[19]));
		send_rank(punrank_pkg::rank_t'(tracker.fact_of[20] - 1));
		send_rank(punrank_pkg::rank_t'(tracker.fact_of[20]));
		send_rank(62'h1555_5555_5555_5555);
		send_rank(62'h2AAA_AAAA_AAAA_AAAA);
		send_rank('1);
		// zero length acts as one
		write_length(5'd0);
		send_rank('0);
		send_rank(punrank_pkg::rank_t'(1));
		send_rank('1);
		write_length(5'd2);
		send_rank('0);
		send_rank(punrank_pkg::rank_t'(1));
		send_rank(punrank_pkg::rank_t'(2));
		// lengths above the maximum saturate
		write_length(5'd31);
		send_rank(punrank_pkg::rank_t'(tracker.fact_of[20] - 1));
		send_rank(punrank_pkg::rank_t'(tracker.fact_of[20]));
		write_length(5'd21);
		send_rank('0);
		send_rank(punrank_pkg::rank_t'(tracker.fact_of[20] - 1));

		for (int seg = 0; seg < 9; seg++) begin
			idle_pct = (seg < 3) ? 38 : (seg < 6) ? 78 : 0;
			write_length(seg_len[seg]);
			for (int i = 0; i < SEG_ITEMS; i++) send_rank(pick_rank(tracker.eff_len()));
		end

		drain_words();
		repeat (SETTLE) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("permutation_unrank regression: pass");
		end else begin
			$display("permutation_unrank regression: fail");
		end
		$finish;
	end

endmodule

[sim.f]
src/punrank_pkg.sv
src/permutation_unrank.sv
test/tb_permutation_unrank.sv
